FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the single-wire bus master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int unsigned CFG_WIDTH = 8;
   localparam int unsigned CFG_IDX_WIDTH = 3;
   localparam int unsigned DATA_WIDTH = 8;
   localparam int unsigned TICK_WIDTH = 8;
   localparam int unsigned BIT_IDX_WIDTH = 3;

   // Request action codes
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // Configuration register indexes
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_RESET_TAIL    = 3'd2;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_SLOT_LOW      = 3'd3;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_READ_SAMPLE   = 3'd4;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_READ_HOLD     = 3'd5;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_WRITE_HOLD    = 3'd6;
   localparam logic [CFG_IDX_WIDTH-1:0] CSR_RECOVERY      = 3'd7;

   // Configuration register reset values
   localparam logic [CFG_WIDTH-1:0] RST_RESET_LOW     = 8'd100;
   localparam logic [CFG_WIDTH-1:0] RST_PRESENCE_WAIT = 8'd14;
   localparam logic [CFG_WIDTH-1:0] RST_RESET_TAIL    = 8'd100;
   localparam logic [CFG_WIDTH-1:0] RST_SLOT_LOW      = 8'd2;
   localparam logic [CFG_WIDTH-1:0] RST_READ_SAMPLE   = 8'd1;
   localparam logic [CFG_WIDTH-1:0] RST_READ_HOLD     = 8'd10;
   localparam logic [CFG_WIDTH-1:0] RST_WRITE_HOLD    = 8'd20;
   localparam logic [CFG_WIDTH-1:0] RST_RECOVERY      = 8'd12;

   // Timing registers, all in ticks
   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_ticks;
      logic [CFG_WIDTH-1:0] presence_wait_ticks;
      logic [CFG_WIDTH-1:0] reset_tail_ticks;
      logic [CFG_WIDTH-1:0] slot_low_ticks;
      logic [CFG_WIDTH-1:0] read_sample_ticks;
      logic [CFG_WIDTH-1:0] read_hold_ticks;
      logic [CFG_WIDTH-1:0] write_hold_ticks;
      logic [CFG_WIDTH-1:0] recovery_ticks;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic                  drive_enable;
      logic                  drive_level;
      logic                  busy_res;
      logic                  done_res;
      logic                  presence;
      logic [DATA_WIDTH-1:0] read_data;
   } result_type;

endpackage

FILE: src/owbm_csr.sv
// ----------------------------------------------------------------------------
// owbm_csr
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_csr
   import owbm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CFG_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_write_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low_ticks     = csr_write_data;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_ticks = csr_write_data;
            CSR_RESET_TAIL:    cfg_in.reset_tail_ticks    = csr_write_data;
            CSR_SLOT_LOW:      cfg_in.slot_low_ticks      = csr_write_data;
            CSR_READ_SAMPLE:   cfg_in.read_sample_ticks   = csr_write_data;
            CSR_READ_HOLD:     cfg_in.read_hold_ticks     = csr_write_data;
            CSR_WRITE_HOLD:    cfg_in.write_hold_ticks    = csr_write_data;
            CSR_RECOVERY:      cfg_in.recovery_ticks      = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RST_RESET_LOW;
         cfg_ff.presence_wait_ticks <= RST_PRESENCE_WAIT;
         cfg_ff.reset_tail_ticks    <= RST_RESET_TAIL;
         cfg_ff.slot_low_ticks      <= RST_SLOT_LOW;
         cfg_ff.read_sample_ticks   <= RST_READ_SAMPLE;
         cfg_ff.read_hold_ticks     <= RST_READ_HOLD;
         cfg_ff.write_hold_ticks    <= RST_WRITE_HOLD;
         cfg_ff.recovery_ticks      <= RST_RECOVERY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq
// Bus sequencer: phase state machine, tick counter, bit shifter and
// line state. Advances one tick for every accepted request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owbm_seq
   import owbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  cfg_type               cfg,
   input  logic [1:0]            req_action,
   input  logic [DATA_WIDTH-1:0] req_write_data,
   input  logic                  req_bus_level,
   output result_type            result
);

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_SLOT_LOW = 4'd4,
      PH_WR_HOLD  = 4'd5,
      PH_RD_WAIT  = 4'd6,
      PH_RD_HOLD  = 4'd7,
      PH_SLOT_REC = 4'd8
   } phase_type;

   phase_type                phase_ff, phase_in, phase_cur;
   logic [TICK_WIDTH-1:0]    tick_ff, tick_in, tick_cur;
   logic [BIT_IDX_WIDTH-1:0] bit_ff, bit_in, bit_cur;
   logic [DATA_WIDTH-1:0]    shift_ff, shift_in, shift_cur;
   logic [1:0]               op_ff, op_in, op_cur;
   logic                     present_ff, present_in;
   logic                     line_en_ff, line_en_in;
   logic                     line_val_ff, line_val_in;
   logic [DATA_WIDTH-1:0]    rx_ff, rx_in;
   logic                     start;
   logic                     busy;
   logic                     done;
   logic                     last_tick;
   logic [TICK_WIDTH-1:0]    len_raw, len;

   // Start a command only from idle
   always_comb begin
      start     = (phase_ff == PH_IDLE) && (req_action != ACT_NONE);
      phase_cur = phase_ff;
      tick_cur  = tick_ff;
      bit_cur   = bit_ff;
      op_cur    = op_ff;
      shift_cur = shift_ff;
      if (start) begin
         op_cur   = req_action;
         tick_cur = '0;
         bit_cur  = '0;
         if (req_action == ACT_RESET) begin
            phase_cur = PH_RST_LOW;
         end else begin
            phase_cur = PH_SLOT_LOW;
            shift_cur = (req_action == ACT_WRITE) ? req_write_data : '0;
         end
      end
   end

   // Drive the line for the phase of this tick
   always_comb begin
      line_en_in  = line_en_ff;
      line_val_in = line_val_ff;
      busy        = 1'b1;
      case (phase_cur)
         PH_RST_LOW, PH_SLOT_LOW: begin
            line_en_in  = 1'b1;
            line_val_in = 1'b0;
         end
         PH_RST_WAIT, PH_RST_TAIL: begin
            line_en_in  = 1'b0;
            line_val_in = 1'b1;
         end
         PH_WR_HOLD: begin
            line_en_in  = 1'b1;
            line_val_in = shift_cur[0];
         end
         PH_RD_WAIT, PH_RD_HOLD: begin
            line_en_in = 1'b0;
         end
         PH_SLOT_REC: begin
            line_en_in  = 1'b1;
            line_val_in = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Select the length of the running phase, zero counts as one
   always_comb begin
      case (phase_cur)
         PH_RST_LOW:  len_raw = cfg.reset_low_ticks;
         PH_RST_WAIT: len_raw = cfg.presence_wait_ticks;
         PH_RST_TAIL: len_raw = cfg.reset_tail_ticks;
         PH_SLOT_LOW: len_raw = cfg.slot_low_ticks;
         PH_RD_WAIT:  len_raw = cfg.read_sample_ticks;
         PH_RD_HOLD:  len_raw = cfg.read_hold_ticks;
         PH_WR_HOLD:  len_raw = cfg.write_hold_ticks;
         PH_SLOT_REC: len_raw = cfg.recovery_ticks;
         default:     len_raw = TICK_WIDTH'(1);
      endcase
      len       = (len_raw == '0) ? TICK_WIDTH'(1) : len_raw;
      last_tick = tick_cur >= (len - TICK_WIDTH'(1));
   end

   // Advance the counter and move to the next phase on the last tick
   always_comb begin
      phase_in   = phase_cur;
      tick_in    = tick_cur;
      bit_in     = bit_cur;
      op_in      = op_cur;
      shift_in   = shift_cur;
      present_in = present_ff;
      rx_in      = rx_ff;
      done       = 1'b0;
      if (busy) begin
         if (!last_tick) begin
            tick_in = tick_cur + TICK_WIDTH'(1);
         end else begin
            tick_in = '0;
            case (phase_cur)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
               end
               PH_RST_WAIT: begin
                  present_in = !req_bus_level;
                  phase_in   = PH_RST_TAIL;
               end
               PH_RST_TAIL: begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
               PH_SLOT_LOW: begin
                  phase_in = (op_cur == ACT_READ) ? PH_RD_WAIT : PH_WR_HOLD;
               end
               PH_WR_HOLD: begin
                  phase_in = PH_SLOT_REC;
               end
               PH_RD_WAIT: begin
                  shift_in = {req_bus_level, shift_cur[DATA_WIDTH-1:1]};
                  phase_in = PH_RD_HOLD;
               end
               PH_RD_HOLD: begin
                  phase_in = PH_SLOT_REC;
               end
               default: begin
                  if (op_cur != ACT_READ) begin
                     shift_in = {1'b0, shift_cur[DATA_WIDTH-1:1]};
                  end
                  if (bit_cur == '1) begin
                     if (op_cur == ACT_READ) begin
                        rx_in = shift_cur;
                     end
                     done     = 1'b1;
                     phase_in = PH_IDLE;
                     bit_in   = '0;
                  end else begin
                     bit_in   = bit_cur + BIT_IDX_WIDTH'(1);
                     phase_in = PH_SLOT_LOW;
                  end
               end
            endcase
         end
      end
   end

   // Hold sequencer state, advance one tick per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         op_ff       <= ACT_NONE;
         present_ff  <= 1'b0;
         line_en_ff  <= 1'b1;
         line_val_ff <= 1'b1;
         rx_ff       <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         op_ff       <= op_in;
         present_ff  <= present_in;
         line_en_ff  <= line_en_in;
         line_val_ff <= line_val_in;
         rx_ff       <= rx_in;
      end
   end

   assign result.drive_enable = line_en_in;
   assign result.drive_level  = line_val_in;
   assign result.busy_res     = busy;
   assign result.done_res     = done;
   assign result.presence     = present_in;
   assign result.read_data    = rx_in;

   // A bare tick while idle leaves the sequencer idle
   `ASSERT_NEXT(a_idle_tick_stays_idle, clock, reset, step_en && (phase_ff == PH_IDLE) && (req_action == ACT_NONE), phase_ff == PH_IDLE)
   // Bit index only moves inside byte slots
   `ASSERT_IMPLIES(a_bit_idx_zero_outside_slots, clock, reset, (phase_ff == PH_IDLE) || (phase_ff == PH_RST_LOW) || (phase_ff == PH_RST_WAIT) || (phase_ff == PH_RST_TAIL), bit_ff == '0)

endmodule

FILE: src/onewire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// onewire_bus_master_unit
// Single-wire bus master, one request per 0.5 us bus tick.
// Results: each is valid the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_ready is high; the result register frees as it is taken.
// Reset: synchronous; sequencer idle with the line driven high, timing
// registers at defaults, presence and read byte cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onewire_bus_master_unit
   import owbm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_enable,
   input  logic [CFG_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_write_data,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [DATA_WIDTH-1:0]    req_write_data,
   input  logic                     req_bus_level,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_drive_enable,
   output logic                     rsp_drive_level,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic                     rsp_presence,
   output logic [DATA_WIDTH-1:0]    rsp_read_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   owbm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Take a request whenever the result register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   owbm_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .step_en        (accept),
      .cfg            (cfg),
      .req_action     (req_action),
      .req_write_data (req_write_data),
      .req_bus_level  (req_bus_level),
      .result         (result)
   );

   // Hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_enable = rsp_ff.drive_enable;
   assign rsp_drive_level  = rsp_ff.drive_level;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_presence     = rsp_ff.presence;
   assign rsp_read_data    = rsp_ff.read_data;

   // Every accepted request yields a result in the next cycle
   `ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)

endmodule

FILE: tb/owbm_tick_checker.sv
// ----------------------------------------------------------------------------
// owbm_tick_checker
// Watches the request and result channels of the single-wire bus master,
// runs its own tick-by-tick model of the bus sequencer and compares every
// result against the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module owbm_tick_checker
   import owbm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CFG_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_write_data,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [DATA_WIDTH-1:0]    req_write_data,
   input  logic                     req_bus_level,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     rsp_drive_enable,
   input  logic                     rsp_drive_level,
   input  logic                     rsp_busy_res,
   input  logic                     rsp_done_res,
   input  logic                     rsp_presence,
   input  logic [DATA_WIDTH-1:0]    rsp_read_data,
   output int                       fail_count,
   output int                       pending_count,
   output logic                     op_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_TAIL,
      PH_SLOT_LOW,
      PH_WR_HOLD,
      PH_RD_WAIT,
      PH_RD_HOLD,
      PH_SLOT_REC
   } seq_phase_type;

   // Model of the timing registers and the bus sequencer
   cfg_type                timing;
   seq_phase_type          seq_phase;
   logic [TICK_WIDTH-1:0]  tick_cnt;
   logic [2:0]             bit_idx;
   logic [DATA_WIDTH-1:0]  shift_reg;
   logic [1:0]             op_kind;
   logic                   present_flag;
   logic                   line_en;
   logic                   line_val;
   logic [DATA_WIDTH-1:0]  rx_byte;

   result_type expected_results[$];

   task automatic report_failure(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_failure($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Length of a phase in ticks; a zero register counts as one tick
   function automatic int ticks_in_phase(input seq_phase_type ph);
      logic [CFG_WIDTH-1:0] n;
      case (ph)
         PH_RST_LOW:  n = timing.reset_low_ticks;
         PH_RST_WAIT: n = timing.presence_wait_ticks;
         PH_RST_TAIL: n = timing.reset_tail_ticks;
         PH_SLOT_LOW: n = timing.slot_low_ticks;
         PH_RD_WAIT:  n = timing.read_sample_ticks;
         PH_RD_HOLD:  n = timing.read_hold_ticks;
         PH_WR_HOLD:  n = timing.write_hold_ticks;
         PH_SLOT_REC: n = timing.recovery_ticks;
         default:     n = 8'd1;
      endcase
      return (n == '0) ? 1 : int'(n);
   endfunction

   // Advance the sequencer by one bus tick and form the result it shows
   task automatic advance_tick(input logic [1:0] action,
                               input logic [DATA_WIDTH-1:0] wdata,
                               input logic bus, output result_type res);
      logic busy;
      logic done;
      busy = 1'b0;
      done = 1'b0;

      // start a command only from idle; anything else is dropped
      if (seq_phase == PH_IDLE && action != ACT_NONE) begin
         op_kind  = action;
         tick_cnt = '0;
         bit_idx  = '0;
         if (action == ACT_RESET) begin
            seq_phase = PH_RST_LOW;
         end else begin
            seq_phase = PH_SLOT_LOW;
            shift_reg = (action == ACT_WRITE) ? wdata : '0;
         end
      end

      // line state of the current phase
      if (seq_phase != PH_IDLE) begin
         busy = 1'b1;
         case (seq_phase)
            PH_RST_LOW, PH_SLOT_LOW: begin
               line_en  = 1'b1;
               line_val = 1'b0;
            end
            PH_RST_WAIT, PH_RST_TAIL: begin
               line_en  = 1'b0;
               line_val = 1'b1;
            end
            PH_WR_HOLD: begin
               line_en  = 1'b1;
               line_val = shift_reg[0];
            end
            PH_RD_WAIT, PH_RD_HOLD: begin
               line_en  = 1'b0;
            end
            default: begin
               line_en  = 1'b1;
               line_val = 1'b1;
            end
         endcase
      end

      res.drive_enable = line_en;
      res.drive_level  = line_val;

      // count ticks and move on at the end of each phase
      if (seq_phase != PH_IDLE) begin
         if (int'(tick_cnt) + 1 < ticks_in_phase(seq_phase)) begin
            tick_cnt = tick_cnt + 1'b1;
         end else begin
            tick_cnt = '0;
            case (seq_phase)
               PH_RST_LOW:  seq_phase = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  present_flag = (bus == 1'b0);
                  seq_phase    = PH_RST_TAIL;
               end
               PH_RST_TAIL: begin
                  done      = 1'b1;
                  seq_phase = PH_IDLE;
               end
               PH_SLOT_LOW: seq_phase = (op_kind == ACT_READ) ? PH_RD_WAIT : PH_WR_HOLD;
               PH_WR_HOLD:  seq_phase = PH_SLOT_REC;
               PH_RD_WAIT: begin
                  shift_reg = {bus, shift_reg[7:1]};
                  seq_phase = PH_RD_HOLD;
               end
               PH_RD_HOLD:  seq_phase = PH_SLOT_REC;
               default: begin
                  if (op_kind != ACT_READ)
                     shift_reg = shift_reg >> 1;
                  if (bit_idx == 3'd7) begin
                     if (op_kind == ACT_READ)
                        rx_byte = shift_reg;
                     done      = 1'b1;
                     seq_phase = PH_IDLE;
                     bit_idx   = '0;
                  end else begin
                     bit_idx   = bit_idx + 1'b1;
                     seq_phase = PH_SLOT_LOW;
                  end
               end
            endcase
         end
      end

      res.busy_res  = busy;
      res.done_res  = done;
      res.presence  = present_flag;
      res.read_data = rx_byte;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type got;
      if (reset) begin
         timing.reset_low_ticks     = RST_RESET_LOW;
         timing.presence_wait_ticks = RST_PRESENCE_WAIT;
         timing.reset_tail_ticks    = RST_RESET_TAIL;
         timing.slot_low_ticks      = RST_SLOT_LOW;
         timing.read_sample_ticks   = RST_READ_SAMPLE;
         timing.read_hold_ticks     = RST_READ_HOLD;
         timing.write_hold_ticks    = RST_WRITE_HOLD;
         timing.recovery_ticks      = RST_RECOVERY;
         seq_phase    = PH_IDLE;
         tick_cnt     = '0;
         bit_idx      = '0;
         shift_reg    = '0;
         op_kind      = ACT_NONE;
         present_flag = 1'b0;
         line_en      = 1'b1;
         line_val     = 1'b1;
         rx_byte      = '0;
         expected_results.delete();
      end else begin
         // track register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RESET_LOW:     timing.reset_low_ticks     = csr_write_data;
               CSR_PRESENCE_WAIT: timing.presence_wait_ticks = csr_write_data;
               CSR_RESET_TAIL:    timing.reset_tail_ticks    = csr_write_data;
               CSR_SLOT_LOW:      timing.slot_low_ticks      = csr_write_data;
               CSR_READ_SAMPLE:   timing.read_sample_ticks   = csr_write_data;
               CSR_READ_HOLD:     timing.read_hold_ticks     = csr_write_data;
               CSR_WRITE_HOLD:    timing.write_hold_ticks    = csr_write_data;
               default:           timing.recovery_ticks      = csr_write_data;
            endcase
         end

         // compare a taken result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.drive_enable = rsp_drive_enable;
            got.drive_level  = rsp_drive_level;
            got.busy_res     = rsp_busy_res;
            got.done_res     = rsp_done_res;
            got.presence     = rsp_presence;
            got.read_data    = rsp_read_data;
            if (expected_results.size() == 0) begin
               report_failure($sformatf("result %h with no request pending", got));
            end else begin
               want = expected_results.pop_front();
               check_field("drive_enable", 8'(got.drive_enable), 8'(want.drive_enable));
               check_field("drive_level", 8'(got.drive_level), 8'(want.drive_level));
               check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
               check_field("done_res", 8'(got.done_res), 8'(want.done_res));
               check_field("presence", 8'(got.presence), 8'(want.presence));
               check_field("read_data", got.read_data, want.read_data);
            end
         end

         // predict the result of an accepted request
         if (req_valid && req_ready) begin
            advance_tick(req_action, req_write_data, req_bus_level, want);
            expected_results.push_back(want);
         end
      end
      pending_count = expected_results.size();
      op_idle       = (seq_phase == PH_IDLE);
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives bus-tick requests and timing register writes into the single-wire
// bus master: default timing, a directed pass over commands and presence /
// read levels, random command streams over several timing settings and
// back-pressure modes, and a final pass with the longest reset timing.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import owbm_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CFG_IDX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0]     csr_write_data;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_action;
   logic [DATA_WIDTH-1:0]    req_write_data;
   logic                     req_bus_level;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_drive_enable;
   logic                     rsp_drive_level;
   logic                     rsp_busy_res;
   logic                     rsp_done_res;
   logic                     rsp_presence;
   logic [DATA_WIDTH-1:0]    rsp_read_data;

   int   fail_count;
   int   pending_count;
   logic op_idle;
   int   cycle_count = 0;
   int   req_idle_pct = 0;
   int   rsp_stall_pct = 0;

   onewire_bus_master_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_write_data   (req_write_data),
      .req_bus_level    (req_bus_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_drive_level  (rsp_drive_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_presence     (rsp_presence),
      .rsp_read_data    (rsp_read_data)
   );

   owbm_tick_checker tick_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_write_data   (req_write_data),
      .req_bus_level    (req_bus_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_drive_level  (rsp_drive_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_presence     (rsp_presence),
      .rsp_read_data    (rsp_read_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .op_idle          (op_idle)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result channel at random
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic set_idling(input int mode);
      req_idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 38 : 0;
      rsp_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 38 : 0;
   endtask

   // Offer one request, optionally after an idle gap, and hold it until taken
   task automatic send_request(input logic [1:0] action,
                               input logic [DATA_WIDTH-1:0] data, input logic bus);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_write_data <= data;
      req_bus_level  <= bus;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Tick the bus until the running operation ends
   task automatic finish_op(input logic bus);
      while (!op_idle)
         send_request(ACT_NONE, 8'($urandom_range(255)), bus);
   endtask

   task automatic run_op(input logic [1:0] action,
                         input logic [DATA_WIDTH-1:0] data, input logic bus);
      send_request(action, data, bus);
      finish_op(bus);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
   endtask

   // Reprogram all timing registers once the sequencer is idle
   task automatic load_timing(input cfg_type t);
      finish_op(1'($urandom_range(1)));
      quiesce();
      write_reg(CSR_RESET_LOW,     t.reset_low_ticks);
      write_reg(CSR_PRESENCE_WAIT, t.presence_wait_ticks);
      write_reg(CSR_RESET_TAIL,    t.reset_tail_ticks);
      write_reg(CSR_SLOT_LOW,      t.slot_low_ticks);
      write_reg(CSR_READ_SAMPLE,   t.read_sample_ticks);
      write_reg(CSR_READ_HOLD,     t.read_hold_ticks);
      write_reg(CSR_WRITE_HOLD,    t.write_hold_ticks);
      write_reg(CSR_RECOVERY,      t.recovery_ticks);
      csr_write_enable <= 1'b0;
   endtask

   function automatic cfg_type uniform_timing(input logic [CFG_WIDTH-1:0] v);
      return cfg_type'({8{v}});
   endfunction

   // Random commands: frequent while idle, occasional noise while busy
   task automatic run_random(input int count);
      logic [1:0] action;
      int         cmd_pct;
      repeat (count) begin
         cmd_pct = op_idle ? 40 : 6;
         action  = ACT_NONE;
         if ($urandom_range(99) < cmd_pct)
            action = 2'($urandom_range(ACT_READ, ACT_RESET));
         send_request(action, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   initial begin : stimulus
      cfg_type timing;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_RESET_LOW;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_action       = ACT_NONE;
      req_write_data   = '0;
      req_bus_level    = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default timing straight out of reset
      run_op(ACT_RESET, 8'h00, 1'b0);
      run_op(ACT_WRITE, 8'($urandom_range(255)), 1'b1);
      run_op(ACT_READ, 8'h00, 1'b1);

      // directed pass at the shortest timing
      load_timing(uniform_timing(8'd1));
      run_op(ACT_NONE, 8'hFF, 1'b1);
      run_op(ACT_RESET, 8'h00, 1'b0);
      run_op(ACT_RESET, 8'hFF, 1'b1);
      run_op(ACT_WRITE, 8'hFF, 1'b1);
      run_op(ACT_WRITE, 8'h00, 1'b0);
      run_op(ACT_WRITE, 8'hA5, 1'b1);
      run_op(ACT_READ, 8'hFF, 1'b1);
      run_op(ACT_READ, 8'h00, 1'b0);
      // commands during a running write are dropped
      send_request(ACT_WRITE, 8'h3C, 1'b1);
      send_request(ACT_READ, 8'hC3, 1'b0);
      run_op(ACT_RESET, 8'h5A, 1'b0);

      // random streams over each back-pressure mode
      for (int mode = 0; mode < 4; mode++) begin
         set_idling(mode);
         for (int i = 0; i < 8; i++)
            timing[i*CFG_WIDTH +: CFG_WIDTH] = 8'($urandom_range(4));
         load_timing(timing);
         run_random(50);
         load_timing(uniform_timing((mode % 2 == 0) ? 8'd1 : 8'd0));
         run_random(40);
      end

      // longest reset pulse and tail, then short byte slots
      set_idling(3);
      timing                  = uniform_timing(8'd1);
      timing.reset_low_ticks  = 8'd255;
      timing.reset_tail_ticks = 8'd255;
      load_timing(timing);
      run_op(ACT_RESET, 8'h00, 1'b0);
      run_op(ACT_WRITE, 8'h96, 1'b1);
      run_op(ACT_READ, 8'h00, 1'($urandom_range(1)));

      // drain and let the pipeline settle
      quiesce();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/owbm_pkg.sv
src/owbm_csr.sv
src/owbm_seq.sv
src/onewire_bus_master_unit.sv
tb/owbm_tick_checker.sv
tb/tb_top.sv
